>>> rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Operation codes carried on the operation field.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FIND  = 2'd1,
    OP_FREE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_NO_REGION  = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_QUOT,
    S_CHECK,
    S_ALLOC_WALK,
    S_SHIFT_UP,
    S_WRITE_NEW,
    S_LOOKUP,
    S_SHIFT_DOWN,
    S_DONE
  } state_t;

endpackage

>>> rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Keeps an address-ordered table of allocated blocks in one region and
// serves allocate, find, free and clear requests with a first-fit search.
// ----------------------------------------------------------------------------
// Usage:
// Request words arrive on the in_valid/in_ready channel with operation,
// request_size and start_offset. One result word leaves on the
// out_valid/out_ready channel for every request, carrying status,
// block_offset and block_length. The region size is written through
// cfg_write_en/cfg_write_data; the user must write it only while the block
// is idle, as the block itself does not enforce it. The block works on one
// request at a time. A clear goes straight from acceptance to the done
// state. Find walks the table one entry per cycle. Free moves each later
// entry down one place after the match. Allocate walks the gaps one entry
// per cycle and then moves later entries up one per cycle; walk and moves
// together cover entry_count + 1 entries. When ALIGN_BYTES is not a power
// of two, the reciprocal-multiply states S_MOD and S_QUOT for the alignment
// test come first. The rate is set by the single read port of the entry memory.
// A result waits in an output register, so a stalled receiver does not keep
// the next request from being accepted; only the following completion waits
// for the register to drain. Reset empties the table and zeroes the region
// size; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 16,
  parameter int ALIGN_BYTES = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] request_size,
  input  logic [31:0] start_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] block_offset,
  output logic [31:0] block_length
);

  // Placed starts never exceed the region size, so stored starts need at
  // most 32 bits even when offsets are wider.
  localparam int SW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam bit ALIGN_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);
  localparam logic [31:0] ALIGN_MASK = 32'(ALIGN_BYTES - 1);
  localparam logic [31:0] LIMIT_MASK = 32'((64'(1) << SW) - 64'(1));
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);
  // Reciprocal of the alignment for an exact 32-bit quotient:
  // q = (t + ((x - t) >> 1)) >> (L - 1) with t the high word of x * RECIP.
  localparam int ALIGN_LOG = $clog2(ALIGN_BYTES);
  localparam int QUOT_SHIFT = (ALIGN_LOG > 0) ? ALIGN_LOG - 1 : 0;
  localparam logic [63:0] ALIGN_DIFF = (64'(1) << ALIGN_LOG) - 64'(ALIGN_BYTES);
  localparam logic [63:0] RECIP_WIDE = ((ALIGN_DIFF << 32) / 64'(ALIGN_BYTES)) + 64'(1);
  localparam logic [31:0] ALIGN_RECIP = RECIP_WIDE[31:0];

  // Entry memory: one write port and one registered read port.
  logic [SW-1:0] mem_start [MAX_BLOCKS];
  logic [31:0]   mem_len   [MAX_BLOCKS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [SW-1:0] mem_wstart;
  logic [31:0]   mem_wlen;
  logic [IW-1:0] mem_raddr;
  logic [SW-1:0] rd_start;
  logic [31:0]   rd_len;

  state_t        state, state_next;
  logic [31:0]   region_size;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [32:0]   prev_end, prev_end_next;
  logic [SW-1:0] new_ofs, new_ofs_next;
  op_t           op_r, op_r_next;
  logic [31:0]   req_r, req_r_next;
  logic [31:0]   so_r, so_r_next;
  logic [31:0]   mul_hi, mul_hi_next;
  logic [31:0]   quot, quot_next;
  status_t       res_status, res_status_next;
  logic [31:0]   res_ofs, res_ofs_next;
  logic [31:0]   res_len, res_len_next;
  logic          out_valid_next;
  logic [2:0]    status_next;
  logic [31:0]   block_offset_next, block_length_next;

  // Shared gap unit and helpers.
  logic [31:0] limit;
  logic [31:0] rd_start32;
  logic [31:0] right_raw, right_edge;
  logic [32:0] left_edge;
  logic [33:0] gap;
  logic        fits, skip_head, hit;
  logic        misaligned;
  logic [63:0] recip_prod;
  logic [63:0] quot_prod;
  logic        match;
  logic        out_free;
  logic [CW-1:0] idx_inc;

  assign limit      = region_size & LIMIT_MASK;
  assign rd_start32 = 32'(rd_start);
  assign idx_inc    = idx + CW'(1);

  // Gap between the end of the previous block (or offset zero) and the
  // start of the current block (or the region end), cut at the region end.
  assign right_raw  = (idx < count) ? rd_start32 : limit;
  assign right_edge = (right_raw < limit) ? right_raw : limit;
  assign left_edge  = (idx == '0) ? 33'd0 : prev_end;
  assign gap        = {2'b00, right_edge} - {1'b0, left_edge};
  assign fits       = !gap[33] && (gap[32:0] >= {1'b0, req_r});
  // The head gap only counts when the first block does not start at zero.
  assign skip_head  = (idx == '0) && (count != '0) && (rd_start == '0);
  assign hit        = fits && !skip_head;

  // Alignment test for other alignments: the size is aligned exactly when
  // the quotient times the alignment gives the size back.
  assign recip_prod = {32'd0, req_r} * {32'd0, ALIGN_RECIP};
  assign quot_prod  = {32'd0, quot} * 64'(ALIGN_BYTES);

  assign misaligned = ALIGN_POW2 ? ((req_r & ALIGN_MASK) != '0)
                                 : (quot_prod != {32'd0, req_r});
  assign match      = (idx < count) && (rd_start32 == so_r);
  assign out_free   = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(operation))
            OP_CLEAR: state_next = S_DONE;
            OP_ALLOC: state_next = ALIGN_POW2 ? S_CHECK : S_MOD;
            OP_FIND, OP_FREE: state_next = S_LOOKUP;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MOD: state_next = S_QUOT;
      S_QUOT: state_next = S_CHECK;
      S_CHECK: begin
        if (misaligned || region_size == '0 || count >= MAX_COUNT) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ALLOC_WALK;
        end
      end
      S_ALLOC_WALK: begin
        if (hit) begin
          state_next = (idx < count) ? S_SHIFT_UP : S_WRITE_NEW;
        end else if (idx == count) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (idx == pos) begin
          state_next = S_WRITE_NEW;
        end
      end
      S_WRITE_NEW: state_next = S_DONE;
      S_LOOKUP: begin
        if (idx == count) begin
          state_next = S_DONE;
        end else if (match) begin
          if (op_r == OP_FREE && idx_inc < count) begin
            state_next = S_SHIFT_DOWN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SHIFT_DOWN: begin
        if (idx_inc == count) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath, memory control and result logic.
  always_comb begin
    count_next        = count;
    idx_next          = idx;
    pos_next          = pos;
    prev_end_next     = prev_end;
    new_ofs_next      = new_ofs;
    op_r_next         = op_r;
    req_r_next        = req_r;
    so_r_next         = so_r;
    mul_hi_next       = mul_hi;
    quot_next         = quot;
    res_status_next   = res_status;
    res_ofs_next      = res_ofs;
    res_len_next      = res_len;
    mem_we            = 1'b0;
    mem_waddr         = idx[IW-1:0];
    mem_wstart        = rd_start;
    mem_wlen          = rd_len;
    out_valid_next    = out_valid && !out_ready;
    status_next       = status;
    block_offset_next = block_offset;
    block_length_next = block_length;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next       = op_t'(operation);
          req_r_next      = request_size;
          so_r_next       = start_offset;
          idx_next        = '0;
          res_status_next = ST_OK;
          res_ofs_next    = '0;
          res_len_next    = '0;
          if (op_t'(operation) == OP_CLEAR) begin
            count_next = '0;
          end
        end
      end
      S_MOD: begin
        mul_hi_next = recip_prod[63:32];
      end
      S_QUOT: begin
        quot_next = (mul_hi + ((req_r - mul_hi) >> 1)) >> QUOT_SHIFT;
      end
      S_CHECK: begin
        idx_next = '0;
        if (misaligned) begin
          res_status_next = ST_MISALIGNED;
        end else if (region_size == '0) begin
          res_status_next = ST_NO_REGION;
        end else if (count >= MAX_COUNT) begin
          res_status_next = ST_FULL;
        end
      end
      S_ALLOC_WALK: begin
        if (hit) begin
          pos_next     = idx;
          new_ofs_next = left_edge[SW-1:0];
          if (idx < count) begin
            idx_next = count - CW'(1);
          end
        end else if (idx == count) begin
          res_status_next = ST_NO_SPACE;
        end else begin
          prev_end_next = {1'b0, rd_start32} + {1'b0, rd_len};
          idx_next      = idx_inc;
        end
      end
      S_SHIFT_UP: begin
        // Entry idx moves up one place; the next read is the entry below.
        mem_we    = 1'b1;
        mem_waddr = idx_inc[IW-1:0];
        if (idx != pos) begin
          idx_next = idx - CW'(1);
        end
      end
      S_WRITE_NEW: begin
        mem_we       = 1'b1;
        mem_waddr    = pos[IW-1:0];
        mem_wstart   = new_ofs;
        mem_wlen     = req_r;
        count_next   = count + CW'(1);
        res_ofs_next = 32'(new_ofs);
        res_len_next = req_r;
      end
      S_LOOKUP: begin
        if (idx == count) begin
          res_status_next = ST_NOT_FOUND;
        end else if (match) begin
          if (op_r == OP_FIND) begin
            res_ofs_next = rd_start32;
            res_len_next = rd_len;
          end else if (idx_inc < count) begin
            idx_next = idx_inc;
          end else begin
            count_next = count - CW'(1);
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      S_SHIFT_DOWN: begin
        // Entry idx moves down one place over the freed slot.
        mem_we    = 1'b1;
        mem_waddr = IW'(idx - CW'(1));
        if (idx_inc == count) begin
          count_next = count - CW'(1);
        end else begin
          idx_next = idx_inc;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          status_next       = res_status;
          block_offset_next = res_ofs;
          block_length_next = res_len;
        end
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  assign mem_raddr = idx_next[IW-1:0];
  assign in_ready  = (state == S_IDLE);

  // Entry memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[mem_waddr] <= mem_wstart;
      mem_len[mem_waddr]   <= mem_wlen;
    end
    rd_start <= mem_start[mem_raddr];
    rd_len   <= mem_len[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      out_valid   <= 1'b0;
      region_size <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_write_en) begin
        region_size <= cfg_write_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx          <= idx_next;
    pos          <= pos_next;
    prev_end     <= prev_end_next;
    new_ofs      <= new_ofs_next;
    op_r         <= op_r_next;
    req_r        <= req_r_next;
    so_r         <= so_r_next;
    mul_hi       <= mul_hi_next;
    quot         <= quot_next;
    res_status   <= res_status_next;
    res_ofs      <= res_ofs_next;
    res_len      <= res_len_next;
    status       <= status_next;
    block_offset <= block_offset_next;
    block_length <= block_length_next;
  end

endmodule
